[design/bsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

    // Default grid size; the top level takes these as parameter defaults.
    localparam int GRID_COLS_DEF = 256;
    localparam int GRID_ROWS_DEF = 256;

    // Field widths of one cell and of the input word.
    localparam int PIX_W  = 8;
    localparam int COORD_W = 8;
    localparam int WGT_W  = 8;
    localparam int PROD_W = PIX_W + WGT_W;
    localparam int SUM_W  = 32;
    localparam int TOT_W  = 16;
    localparam int CELL_W = SUM_W + TOT_W + 1;

    // Four parity banks, one for each corner of a 2x2 block.
    localparam int NUM_BANKS = 4;

    // Job queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Command codes on the input word.
    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ       = 1'b1;

    // Kind of job handed to the back.
    typedef enum logic [1:0] {
        JOB_ACC,
        JOB_READ,
        JOB_READ_ZERO
    } t_job_op;

    // One classified job; the bank addresses travel beside it.
    typedef struct packed {
        t_job_op                         op;
        logic                            mark;
        logic [1:0]                      sel;
        logic [NUM_BANKS-1:0][PROD_W-1:0] prod;
        logic [NUM_BANKS-1:0][WGT_W-1:0]  wgt;
    } t_job;

    // States of the back sequencer.
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_UPDATE
    } t_back_state;

    // Status of the back seen by the top level.
    typedef struct packed {
        logic clearing;
        logic updating;
    } t_back_stat;

endpackage

`default_nettype wire

[design/bsa_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsa_front #(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256,
    parameter int ADDR_W    = 14
) (
    input  wire logic                                  i_accept,
    input  wire logic                                  i_command,
    input  wire logic [bsa_pkg::PIX_W-1:0]             i_pixel_value,
    input  wire logic [bsa_pkg::COORD_W-1:0]           i_acc_col,
    input  wire logic [bsa_pkg::COORD_W-1:0]           i_acc_row,
    input  wire logic [bsa_pkg::WGT_W-1:0]             i_weight_nw,
    input  wire logic [bsa_pkg::WGT_W-1:0]             i_weight_ne,
    input  wire logic [bsa_pkg::WGT_W-1:0]             i_weight_sw,
    input  wire logic [bsa_pkg::WGT_W-1:0]             i_weight_se,
    input  wire logic                                  i_edge_pixel,
    output logic                                       o_push,
    output bsa_pkg::t_job                              o_job,
    output logic [bsa_pkg::NUM_BANKS-1:0][ADDR_W-1:0]  o_addr
);
    import bsa_pkg::*;

    localparam int BANK_COLS = (GRID_COLS + 1) / 2;

    logic                     acc_ok;
    logic                     rd_ok;
    logic [COORD_W-1:0]       hc [2];
    logic [COORD_W-1:0]       hr [2];
    logic [ADDR_W-1:0]        rd_addr;

    // Range checks: an accumulate needs its whole 2x2 block inside the grid.
    assign acc_ok = (32'(i_acc_col) < 32'(GRID_COLS - 1))
                 && (32'(i_acc_row) < 32'(GRID_ROWS - 1));
    assign rd_ok  = (32'(i_acc_col) < 32'(GRID_COLS))
                 && (32'(i_acc_row) < 32'(GRID_ROWS));

    // Half coordinates per parity: the even bank sees col or col+1.
    assign hc[0] = {1'b0, i_acc_col[COORD_W-1:1]} + COORD_W'(i_acc_col[0]);
    assign hc[1] = {1'b0, i_acc_col[COORD_W-1:1]};
    assign hr[0] = {1'b0, i_acc_row[COORD_W-1:1]} + COORD_W'(i_acc_row[0]);
    assign hr[1] = {1'b0, i_acc_row[COORD_W-1:1]};

    assign rd_addr = ADDR_W'(32'(hr[1]) * 32'(BANK_COLS) + 32'(hc[1]));

    // Classify the word and build the job for each bank.
    always_comb begin
        logic       dc;
        logic       dr;
        logic [WGT_W-1:0] w;
        o_job.op   = (i_command == CMD_READ) ? (rd_ok ? JOB_READ : JOB_READ_ZERO) : JOB_ACC;
        o_job.mark = i_edge_pixel;
        o_job.sel  = {i_acc_row[0], i_acc_col[0]};
        for (int b = 0; b < NUM_BANKS; b++) begin
            dc = b[0] ^ i_acc_col[0];
            dr = b[1] ^ i_acc_row[0];
            if (dr) begin
                w = dc ? i_weight_se : i_weight_sw;
            end else begin
                w = dc ? i_weight_ne : i_weight_nw;
            end
            o_job.wgt[b]  = w;
            o_job.prod[b] = {{PIX_W{1'b0}}, w} * {{WGT_W{1'b0}}, i_pixel_value};
            if (i_command == CMD_READ) begin
                o_addr[b] = rd_addr;
            end else begin
                o_addr[b] = ADDR_W'(32'(hr[b[1]]) * 32'(BANK_COLS) + 32'(hc[b[0]]));
            end
        end
    end

    // Dropped accumulates never reach the queue.
    assign o_push = i_accept && ((i_command == CMD_READ) || acc_ok);

endmodule

`default_nettype wire

[design/bsa_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsa_queue #(
    parameter int ADDR_W = 14
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_push,
    input  wire bsa_pkg::t_job                         i_job,
    input  wire logic [bsa_pkg::NUM_BANKS-1:0][ADDR_W-1:0] i_addr,
    input  wire logic                                  i_pop,
    output logic                                       o_full,
    output logic                                       o_empty,
    output bsa_pkg::t_job                              o_job,
    output logic [bsa_pkg::NUM_BANKS-1:0][ADDR_W-1:0]  o_addr
);
    import bsa_pkg::*;

    t_job                              r_job  [QUEUE_DEPTH];
    logic [NUM_BANKS-1:0][ADDR_W-1:0]  r_addr [QUEUE_DEPTH];
    logic [QPTR_W-1:0]                 r_wr_ptr;
    logic [QPTR_W-1:0]                 r_rd_ptr;
    logic [QPTR_W:0]                   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_job[r_rd_ptr];
    assign o_addr  = r_addr[r_rd_ptr];

    // Entry storage; no reset needed on payload.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_job[r_wr_ptr]  <= i_job;
            r_addr[r_wr_ptr] <= i_addr;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[design/bsa_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsa_back #(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256,
    parameter int ADDR_W    = 14
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_empty,
    input  wire bsa_pkg::t_job                         i_job,
    input  wire logic [bsa_pkg::NUM_BANKS-1:0][ADDR_W-1:0] i_addr,
    output logic                                       o_pop,
    output bsa_pkg::t_back_stat                        o_stat,
    output logic                                       o_result_valid,
    output logic [bsa_pkg::SUM_W-1:0]                  o_weighted_sum,
    output logic [bsa_pkg::TOT_W-1:0]                  o_weight_total,
    output logic                                       o_border_mark
);
    import bsa_pkg::*;

    localparam int BANK_DEPTH = ((GRID_COLS + 1) / 2) * ((GRID_ROWS + 1) / 2);

    t_back_state                       r_state;
    t_back_state                       n_state;
    logic [ADDR_W-1:0]                 r_clr_addr;
    t_job                              r_job;
    logic [NUM_BANKS-1:0][ADDR_W-1:0]  r_addr;
    logic [NUM_BANKS-1:0][CELL_W-1:0]  r_rdata;
    logic [NUM_BANKS-1:0][CELL_W-1:0]  new_cell;
    logic                              wr_en;
    logic                              clearing;
    logic                              updating;
    logic                              r_res_valid;
    logic [CELL_W-1:0]                 r_res;
    logic [CELL_W-1:0]                 sel_cell;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: begin
                if (r_clr_addr == ADDR_W'(BANK_DEPTH - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = BK_UPDATE;
                end
            end
            BK_UPDATE: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_CLEAR;
            end
        endcase
    end

    // Controls decoded from the state.
    always_comb begin
        clearing = 1'b0;
        updating = 1'b0;
        o_pop    = 1'b0;
        unique case (r_state)
            BK_CLEAR:  clearing = 1'b1;
            BK_IDLE:   o_pop    = !i_empty;
            BK_UPDATE: updating = 1'b1;
            default: begin
                clearing = 1'b0;
            end
        endcase
    end

    assign wr_en = clearing || (updating && (r_job.op == JOB_ACC));
    assign o_stat = '{clearing: clearing, updating: updating};

    // State register and clearing sweep counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Job held for its update cycle.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_addr <= i_addr;
        end
    end

    // Updated contents of each bank's cell: sum, total, then border mark.
    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            new_cell[b][SUM_W-1:0] = r_rdata[b][SUM_W-1:0] + SUM_W'(r_job.prod[b]);
            new_cell[b][SUM_W+TOT_W-1:SUM_W] =
                r_rdata[b][SUM_W+TOT_W-1:SUM_W] + TOT_W'(r_job.wgt[b]);
            new_cell[b][CELL_W-1] = r_rdata[b][CELL_W-1] | r_job.mark;
        end
    end

    // Four parity banks; each is read at the queue head every cycle.
    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        logic [CELL_W-1:0] r_mem [BANK_DEPTH];

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[clearing ? r_clr_addr : r_addr[g]] <= clearing ? '0 : new_cell[g];
            end
            r_rdata[g] <= r_mem[i_addr[g]];
        end
    end

    assign sel_cell = r_rdata[r_job.sel];

    // Result register, one strobe per read job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= updating && (r_job.op != JOB_ACC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (updating) begin
            r_res <= (r_job.op == JOB_READ) ? sel_cell : '0;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_weighted_sum = r_res[SUM_W-1:0];
    assign o_weight_total = r_res[SUM_W+TOT_W-1:SUM_W];
    assign o_border_mark  = r_res[CELL_W-1];

endmodule

`default_nettype wire

[design/bilinear_splat_accumulator_core.sv]
// Bilinear splat accumulator. A word is taken at a rising edge where start is high and
// busy is low. An accumulate word adds weight times intensity and the weight into each
// cell of the 2x2 block at (col,row); a block reaching the last column or row is dropped.
// A read word returns one cell on o_result_valid for a single cycle; the receiver cannot
// hold it off. After reset, busy stays high for a clearing sweep over
// ceil(GRID_COLS/2) * ceil(GRID_ROWS/2) addresses (16384 at the defaults), one address
// of all four parity banks per cycle. Afterwards words go into a four-entry queue. The
// back pops a word and reads the banks in its idle state, then writes them in its update
// state, and takes no new word before that read-modify-write of the bank memories is done;
// busy rises when the queue is full. A read result strobes from the result register,
// which is loaded in the update state that follows the pop of its word.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_splat_accumulator_core #(
    parameter int GRID_COLS = bsa_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = bsa_pkg::GRID_ROWS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_command,
    input  wire logic [bsa_pkg::PIX_W-1:0]      i_pixel_value,
    input  wire logic [bsa_pkg::COORD_W-1:0]    i_acc_col,
    input  wire logic [bsa_pkg::COORD_W-1:0]    i_acc_row,
    input  wire logic [bsa_pkg::WGT_W-1:0]      i_weight_nw,
    input  wire logic [bsa_pkg::WGT_W-1:0]      i_weight_ne,
    input  wire logic [bsa_pkg::WGT_W-1:0]      i_weight_sw,
    input  wire logic [bsa_pkg::WGT_W-1:0]      i_weight_se,
    input  wire logic                           i_edge_pixel,
    output logic                                o_result_valid,
    output logic [bsa_pkg::SUM_W-1:0]           o_weighted_sum,
    output logic [bsa_pkg::TOT_W-1:0]           o_weight_total,
    output logic                                o_border_mark
);
    import bsa_pkg::*;

    localparam int BANK_DEPTH = ((GRID_COLS + 1) / 2) * ((GRID_ROWS + 1) / 2);
    localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic                              accept;
    logic                              push;
    t_job                              f_job;
    logic [NUM_BANKS-1:0][ADDR_W-1:0]  f_addr;
    logic                              q_full;
    logic                              q_empty;
    t_job                              q_job;
    logic [NUM_BANKS-1:0][ADDR_W-1:0]  q_addr;
    logic                              pop;
    t_back_stat                        back_stat;

    // A word is taken whenever the queue has room and the clearing sweep is done.
    assign busy   = back_stat.clearing || q_full;
    assign accept = start && !busy;

    // Front: classify the word and work out bank addresses and products.
    bsa_front #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .i_accept      (accept),
        .i_command     (i_command),
        .i_pixel_value (i_pixel_value),
        .i_acc_col     (i_acc_col),
        .i_acc_row     (i_acc_row),
        .i_weight_nw   (i_weight_nw),
        .i_weight_ne   (i_weight_ne),
        .i_weight_sw   (i_weight_sw),
        .i_weight_se   (i_weight_se),
        .i_edge_pixel  (i_edge_pixel),
        .o_push        (push),
        .o_job         (f_job),
        .o_addr        (f_addr)
    );

    // Job queue between front and back.
    bsa_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_addr  (f_addr),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_job),
        .o_addr  (q_addr)
    );

    // Back: bank memories, read-modify-write and results.
    bsa_back #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS),
        .ADDR_W    (ADDR_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_job          (q_job),
        .i_addr         (q_addr),
        .o_pop          (pop),
        .o_stat         (back_stat),
        .o_result_valid (o_result_valid),
        .o_weighted_sum (o_weighted_sum),
        .o_weight_total (o_weight_total),
        .o_border_mark  (o_border_mark)
    );

    // No result can leave while the store is still being cleared.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.clearing |-> !o_result_valid)
        else $error("result strobe during clearing sweep");

    // Every result follows an update cycle of the back.
    a_result_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(back_stat.updating))
        else $error("result strobe without a preceding update");

    // The queue is never written while full.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("word pushed into a full queue");

    // Each job occupies the back for an idle and an update state, so strobes never touch.
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("back-to-back result strobes");

endmodule

`default_nettype wire
